>>> rtl/core/bfau_pkg.sv
// Shared constants, control word layout and microprogram for the GF(2^m) unit.
// Used by binary_field_arithmetic_unit; depends on nothing else.
`default_nettype none

package bfau_pkg;

  localparam int DATA_W   = 32;
  localparam int POLY_W   = 17;
  localparam int ACC_W    = POLY_W - 1;
  localparam int DIGIT    = 8;
  localparam int W_DIGITS = DATA_W / DIGIT;
  localparam int CNT_W    = $clog2(W_DIGITS);
  localparam int ADDR_W   = 3;
  localparam int PC_W     = 5;

  localparam int FIELD_BITS_DEF = 16;
  localparam int EXP_BITS_DEF   = 32;

  localparam logic [POLY_W-1:0] FIELD_POLY_RST = POLY_W'(283);
  localparam logic [0:0]        REG_FIELD_POLY = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_MUL    = 2'd1,
    CMD_REDUCE = 2'd2,
    CMD_POWER  = 2'd3
  } cmd_t;

  // Microprogram addresses
  localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] PC_MUL_LD_A  = 5'd1;
  localparam logic [PC_W-1:0] PC_MUL_RUN_A = 5'd2;
  localparam logic [PC_W-1:0] PC_MUL_LD_B  = 5'd3;
  localparam logic [PC_W-1:0] PC_MUL_RUN_B = 5'd4;
  localparam logic [PC_W-1:0] PC_RED_LD    = 5'd5;
  localparam logic [PC_W-1:0] PC_RED_RUN   = 5'd6;
  localparam logic [PC_W-1:0] PC_POW_LD    = 5'd7;
  localparam logic [PC_W-1:0] PC_POW_RUN   = 5'd8;
  localparam logic [PC_W-1:0] PC_POW_TEST  = 5'd9;
  localparam logic [PC_W-1:0] PC_POW_BIT   = 5'd10;
  localparam logic [PC_W-1:0] PC_POW_HAVE  = 5'd11;
  localparam logic [PC_W-1:0] PC_MULR_LD   = 5'd12;
  localparam logic [PC_W-1:0] PC_MULR_RUN  = 5'd13;
  localparam logic [PC_W-1:0] PC_POW_SHIFT = 5'd14;
  localparam logic [PC_W-1:0] PC_SQ_LD     = 5'd15;
  localparam logic [PC_W-1:0] PC_SQ_RUN    = 5'd16;
  localparam logic [PC_W-1:0] PC_POW_TAKE  = 5'd17;
  localparam logic [PC_W-1:0] PC_POW_FIN   = 5'd18;
  localparam logic [PC_W-1:0] PC_DONE      = 5'd19;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IN,
    C_CNT_LAST,
    C_EXP_ZERO,
    C_EXP_EVEN,
    C_NO_HAVE,
    C_EXP_NEXT_ZERO,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    SC_KEEP,
    SC_A_FULL,
    SC_A_MASK,
    SC_B_MASK,
    SC_BASE_MASK
  } scan_sel_t;

  typedef enum logic [1:0] {
    AD_KEEP,
    AD_ONE,
    AD_R_MASK,
    AD_BASE_MASK
  } add_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADDEND,
    WR_RES,
    WR_BASE,
    WR_R,
    WR_TAKE,
    WR_POWRES,
    WR_OUT
  } wr_t;

  typedef struct packed {
    cond_t           cond;
    logic            hold;
    logic            dispatch;
    logic [PC_W-1:0] target;
    scan_sel_t       scan;
    add_sel_t        add;
    logic            init;
    logic            cnt_full;
    logic            run;
    wr_t             wr;
    logic            exp_shift;
  } uword_t;

  function automatic uword_t mk_uw(input cond_t cond, input logic hold, input logic dispatch,
                                   input logic [PC_W-1:0] target, input scan_sel_t scan,
                                   input add_sel_t add, input logic init, input logic cnt_full,
                                   input logic run, input wr_t wr, input logic exp_shift);
    uword_t w;
    w.cond      = cond;
    w.hold      = hold;
    w.dispatch  = dispatch;
    w.target    = target;
    w.scan      = scan;
    w.add       = add;
    w.init      = init;
    w.cnt_full  = cnt_full;
    w.run       = run;
    w.wr        = wr;
    w.exp_shift = exp_shift;
    return w;
  endfunction

  // Control store: on a true condition jump to target (or the dispatch address),
  // otherwise hold or fall through to the next step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_IDLE:      w = mk_uw(C_IN, 1'b1, 1'b1, PC_IDLE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_MUL_LD_A:  w = mk_uw(C_NONE, 1'b0, 1'b0, PC_IDLE, SC_A_MASK, AD_ONE,
                              1'b1, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_MUL_RUN_A: w = mk_uw(C_CNT_LAST, 1'b1, 1'b0, PC_MUL_LD_B, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b1, WR_ADDEND, 1'b0);
      PC_MUL_LD_B:  w = mk_uw(C_NONE, 1'b0, 1'b0, PC_IDLE, SC_B_MASK, AD_KEEP,
                              1'b1, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_MUL_RUN_B: w = mk_uw(C_CNT_LAST, 1'b1, 1'b0, PC_DONE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b1, WR_RES, 1'b0);
      PC_RED_LD:    w = mk_uw(C_NONE, 1'b0, 1'b0, PC_IDLE, SC_A_FULL, AD_ONE,
                              1'b1, 1'b1, 1'b0, WR_NONE, 1'b0);
      PC_RED_RUN:   w = mk_uw(C_CNT_LAST, 1'b1, 1'b0, PC_DONE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b1, WR_RES, 1'b0);
      PC_POW_LD:    w = mk_uw(C_NONE, 1'b0, 1'b0, PC_IDLE, SC_A_FULL, AD_ONE,
                              1'b1, 1'b1, 1'b0, WR_NONE, 1'b0);
      PC_POW_RUN:   w = mk_uw(C_CNT_LAST, 1'b1, 1'b0, PC_POW_TEST, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b1, WR_BASE, 1'b0);
      PC_POW_TEST:  w = mk_uw(C_EXP_ZERO, 1'b0, 1'b0, PC_POW_FIN, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_POW_BIT:   w = mk_uw(C_EXP_EVEN, 1'b0, 1'b0, PC_POW_SHIFT, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_POW_HAVE:  w = mk_uw(C_NO_HAVE, 1'b0, 1'b0, PC_POW_TAKE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_MULR_LD:   w = mk_uw(C_NONE, 1'b0, 1'b0, PC_IDLE, SC_BASE_MASK, AD_R_MASK,
                              1'b1, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_MULR_RUN:  w = mk_uw(C_CNT_LAST, 1'b1, 1'b0, PC_POW_SHIFT, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b1, WR_R, 1'b0);
      PC_POW_SHIFT: w = mk_uw(C_EXP_NEXT_ZERO, 1'b0, 1'b0, PC_POW_FIN, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_NONE, 1'b1);
      PC_SQ_LD:     w = mk_uw(C_NONE, 1'b0, 1'b0, PC_IDLE, SC_BASE_MASK, AD_BASE_MASK,
                              1'b1, 1'b0, 1'b0, WR_NONE, 1'b0);
      PC_SQ_RUN:    w = mk_uw(C_CNT_LAST, 1'b1, 1'b0, PC_POW_TEST, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b1, WR_BASE, 1'b0);
      PC_POW_TAKE:  w = mk_uw(C_ALWAYS, 1'b0, 1'b0, PC_POW_SHIFT, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_TAKE, 1'b0);
      PC_POW_FIN:   w = mk_uw(C_ALWAYS, 1'b0, 1'b0, PC_DONE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_POWRES, 1'b0);
      PC_DONE:      w = mk_uw(C_OUT_FREE, 1'b1, 1'b0, PC_IDLE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_OUT, 1'b0);
      default:      w = mk_uw(C_ALWAYS, 1'b0, 1'b0, PC_IDLE, SC_KEEP, AD_KEEP,
                              1'b0, 1'b0, 1'b0, WR_NONE, 1'b0);
    endcase
    return w;
  endfunction

  // Leading one of the polynomial, as a one-hot mask
  function automatic logic [POLY_W-1:0] lead_one(input logic [POLY_W-1:0] p);
    logic [POLY_W-1:0] t;
    t = '0;
    for (int i = 0; i < POLY_W; i++) begin
      if (p[i]) t = POLY_W'(1) << i;
    end
    return t;
  endfunction

  // Horner step over one digit, MSB first: acc = acc*x mod p, plus addend per bit.
  // acc and addend stay below the leading term of p.
  function automatic logic [ACC_W-1:0] digit_step(input logic [ACC_W-1:0] acc,
                                                  input logic [DIGIT-1:0] bits,
                                                  input logic [ACC_W-1:0] addend,
                                                  input logic [POLY_W-1:0] poly,
                                                  input logic [POLY_W-1:0] top);
    logic [POLY_W-1:0] t;
    logic [ACC_W-1:0]  v;
    v = acc;
    for (int i = DIGIT - 1; i >= 0; i--) begin
      t = {v, 1'b0};
      if ((t & top) != '0) t = t ^ poly;
      v = t[ACC_W-1:0] ^ (bits[i] ? addend : '0);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/binary_field_arithmetic_unit.sv
// The digit-serial reducer/multiplier (8 bits per cycle) is shared by multiply, reduce and power.
// One request at a time: the next is accepted the cycle after the result is registered.
// Synchronous active-low reset idles the sequencer, drops out_valid, sets field_poly to 283.
// Microcoded GF(2^m) add/multiply/reduce/power unit; depends on bfau_pkg.
`default_nettype none

module binary_field_arithmetic_unit #(
  parameter int FIELD_BITS = bfau_pkg::FIELD_BITS_DEF,
  parameter int EXP_BITS   = bfau_pkg::EXP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [bfau_pkg::DATA_W-1:0]   in_operand_a,
  input  wire logic [bfau_pkg::DATA_W-1:0]   in_operand_b,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bfau_pkg::DATA_W-1:0]        out_result,
  output logic                               out_bad_poly,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfau_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bfau_pkg::DATA_W-1:0]   pwdata,
  output logic [bfau_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int DATA_W   = bfau_pkg::DATA_W;
  localparam int POLY_W   = bfau_pkg::POLY_W;
  localparam int ACC_W    = bfau_pkg::ACC_W;
  localparam int DIGIT    = bfau_pkg::DIGIT;
  localparam int CNT_W    = bfau_pkg::CNT_W;
  localparam int PC_W     = bfau_pkg::PC_W;
  localparam int ADDR_HI  = bfau_pkg::ADDR_W - 1;
  localparam int F_DIGITS = (FIELD_BITS + DIGIT - 1) / DIGIT;
  localparam int F_SHIFT  = DATA_W - F_DIGITS * DIGIT;
  localparam logic [DATA_W:0]   F_ONE = (DATA_W + 1)'(1) << FIELD_BITS;
  localparam logic [DATA_W-1:0] FMASK = DATA_W'(F_ONE - (DATA_W + 1)'(1));

  logic [PC_W-1:0]   pc_r, pc_nxt, disp_pc;
  bfau_pkg::uword_t  uw;
  logic              cond_true, step_done, in_go, bad_in, out_free;
  logic [POLY_W-1:0] field_poly_r, ptop_r;
  logic [DATA_W-1:0] a_r, b_r, scan_r, res_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [ACC_W-1:0]  acc_r, addend_r, base_r, r_r, acc_step;
  logic [CNT_W-1:0]  cnt_r;
  logic              have_r, bad_r;
  logic              out_valid_r, out_bad_poly_r;
  logic [DATA_W-1:0] out_result_r;

  assign uw        = bfau_pkg::ucode(pc_r);
  assign in_stall  = (pc_r != bfau_pkg::PC_IDLE);
  assign in_go     = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign bad_in    = (in_cmd != bfau_pkg::CMD_ADD) && (field_poly_r[POLY_W-1:1] == '0);
  assign acc_step  = bfau_pkg::digit_step(acc_r, scan_r[DATA_W-1 -: DIGIT], addend_r,
                                          field_poly_r, ptop_r);

  always_comb begin
    case (uw.cond)
      bfau_pkg::C_ALWAYS:        cond_true = 1'b1;
      bfau_pkg::C_IN:            cond_true = in_go;
      bfau_pkg::C_CNT_LAST:      cond_true = (cnt_r == '0);
      bfau_pkg::C_EXP_ZERO:      cond_true = (exp_r == '0);
      bfau_pkg::C_EXP_EVEN:      cond_true = !exp_r[0];
      bfau_pkg::C_NO_HAVE:       cond_true = !have_r;
      bfau_pkg::C_EXP_NEXT_ZERO: cond_true = ((exp_r >> 1) == '0);
      bfau_pkg::C_OUT_FREE:      cond_true = out_free;
      default:                   cond_true = 1'b0;
    endcase
  end

  assign step_done = cond_true || !uw.hold;

  always_comb begin
    case (in_cmd)
      bfau_pkg::CMD_MUL:    disp_pc = bfau_pkg::PC_MUL_LD_A;
      bfau_pkg::CMD_REDUCE: disp_pc = bfau_pkg::PC_RED_LD;
      bfau_pkg::CMD_POWER:  disp_pc = bfau_pkg::PC_POW_LD;
      default:              disp_pc = bfau_pkg::PC_DONE;
    endcase
    if (bad_in) disp_pc = bfau_pkg::PC_DONE;
  end

  always_comb begin
    if (cond_true) begin
      pc_nxt = uw.dispatch ? disp_pc : uw.target;
    end else if (uw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // Sequencer, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= bfau_pkg::PC_IDLE;
      out_valid_r  <= 1'b0;
      field_poly_r <= bfau_pkg::FIELD_POLY_RST;
    end else begin
      pc_r <= pc_nxt;
      if (step_done && uw.wr == bfau_pkg::WR_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && paddr[ADDR_HI:2] == bfau_pkg::REG_FIELD_POLY) begin
        field_poly_r <= pwdata[POLY_W-1:0];
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_go) begin
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      exp_r  <= EXP_BITS'(64'(in_operand_b));
      have_r <= 1'b0;
      bad_r  <= bad_in;
      res_r  <= (in_cmd == bfau_pkg::CMD_ADD) ? (in_operand_a ^ in_operand_b) : '0;
      ptop_r <= bfau_pkg::lead_one(field_poly_r);
    end

    if (uw.init) begin
      acc_r <= '0;
      cnt_r <= uw.cnt_full ? CNT_W'(bfau_pkg::W_DIGITS - 1) : CNT_W'(F_DIGITS - 1);
    end else if (uw.run) begin
      acc_r <= acc_step;
      cnt_r <= cnt_r - CNT_W'(1);
    end

    // Multiplier operands are left-aligned so only the field digits are scanned
    if (uw.run) begin
      scan_r <= scan_r << DIGIT;
    end else begin
      case (uw.scan)
        bfau_pkg::SC_A_FULL:    scan_r <= a_r;
        bfau_pkg::SC_A_MASK:    scan_r <= (a_r & FMASK) << F_SHIFT;
        bfau_pkg::SC_B_MASK:    scan_r <= (b_r & FMASK) << F_SHIFT;
        bfau_pkg::SC_BASE_MASK: scan_r <= (DATA_W'(base_r) & FMASK) << F_SHIFT;
        default:                scan_r <= scan_r;
      endcase
    end

    case (uw.add)
      bfau_pkg::AD_ONE:       addend_r <= ACC_W'(1);
      bfau_pkg::AD_R_MASK:    addend_r <= r_r & FMASK[ACC_W-1:0];
      bfau_pkg::AD_BASE_MASK: addend_r <= base_r & FMASK[ACC_W-1:0];
      default: ;
    endcase

    if (uw.exp_shift) exp_r <= exp_r >> 1;

    if (step_done) begin
      case (uw.wr)
        bfau_pkg::WR_ADDEND: addend_r <= acc_step;
        bfau_pkg::WR_RES:    res_r    <= DATA_W'(acc_step);
        bfau_pkg::WR_BASE:   base_r   <= acc_step;
        bfau_pkg::WR_R:      r_r      <= acc_step;
        bfau_pkg::WR_TAKE: begin
          r_r    <= base_r;
          have_r <= 1'b1;
        end
        bfau_pkg::WR_POWRES: res_r <= have_r ? DATA_W'(r_r) : DATA_W'(1);
        bfau_pkg::WR_OUT: begin
          out_result_r   <= res_r;
          out_bad_poly_r <= bad_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_result   = out_result_r;
  assign out_bad_poly = out_bad_poly_r;
  assign pready       = 1'b1;
  assign prdata       = (paddr[ADDR_HI:2] == bfau_pkg::REG_FIELD_POLY) ?
                        DATA_W'(field_poly_r) : '0;

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_poly_r) |-> (out_result_r == '0))
    else $error("bad polynomial result not zero");

  a_fast_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && (in_cmd == bfau_pkg::CMD_ADD || bad_in)) |=> (pc_r == bfau_pkg::PC_DONE))
    else $error("add or bad polynomial request did not go straight to done");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    uw.run |-> ({1'b0, acc_r} < ptop_r))
    else $error("accumulator not reduced below polynomial degree");

  a_pow_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == bfau_pkg::PC_POW_FIN) |-> (exp_r == '0))
    else $error("power finished with exponent bits left");
`endif

endmodule

`default_nettype wire
